>>> design/edd_pkg.sv
package edd_pkg;

  localparam int PIX_W          = 8;
  localparam int LINE_WIDTH_W   = 11;
  localparam int THRESHOLD_W    = 8;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 11;
  localparam int LINE_ERR_W     = 13;

  localparam int DEFAULT_MAX_LINE_WIDTH = 1024;

  localparam logic [LINE_WIDTH_W-1:0] DEFAULT_LINE_WIDTH = 11'd640;
  localparam logic [THRESHOLD_W-1:0]  DEFAULT_THRESHOLD  = 8'd128;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_THRESHOLD  = 2'd1
  } edd_reg_e;

endpackage

>>> design/edd_line_mem.sv
module edd_line_mem
  import edd_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_MAX_LINE_WIDTH,
  parameter int DATA_W = LINE_ERR_W,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/error_diffusion_dither.sv
// Each pixel passes the second-stage register, then the output register, before its result
// transfers on the m_axis side.
// One pixel per clock unless the output stalls; line store: one read and one write per cycle.
// A row's last pixel writes up to two line entries; the second lands in the next free write cycle.
// Reset: control, configuration and error carries clear at once; line store contents
// stay undefined and are not used while the first row of a frame writes them.
module error_diffusion_dither
  import edd_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = DEFAULT_MAX_LINE_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel
  input  logic                    s_axis_tuser,   // [0] frame_start
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [PIX_W-1:0]        m_axis_tdata,   // [7:0] out_pixel
  output logic                    m_axis_tlast,   // row_end
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int WW = (AW + 1 > LINE_WIDTH_W) ? AW + 1 : LINE_WIDTH_W;

  // configuration
  logic [LINE_WIDTH_W-1:0] line_width_q;
  logic [THRESHOLD_W-1:0]  threshold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= DEFAULT_LINE_WIDTH;
      threshold_q  <= DEFAULT_THRESHOLD;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LINE_WIDTH: line_width_q <= cfg_data_i[LINE_WIDTH_W-1:0];
        REG_THRESHOLD:  threshold_q  <= cfg_data_i[THRESHOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s_xfer, s1_adv, out_free;
  logic s1_v_q, out_v_q;

  assign out_free      = !out_v_q || m_axis_tready;
  assign s1_adv        = s1_v_q && out_free;
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // column tracking at input transfer
  logic [AW-1:0]  col_q, c_in;
  logic           first_q;
  logic [WW-1:0]  w_cfg, w_max, w_eff;
  logic           last_in, use_in;

  assign w_cfg   = WW'(line_width_q);
  assign w_max   = WW'(MAX_LINE_WIDTH);
  assign w_eff   = (line_width_q == '0) ? WW'(1) : ((w_cfg > w_max) ? w_max : w_cfg);
  assign c_in    = s_axis_tuser ? '0 : col_q;
  assign last_in = (WW'(c_in) + WW'(1)) >= w_eff;
  assign use_in  = !(s_axis_tuser || first_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (s_xfer) begin
      col_q   <= last_in ? '0 : c_in + AW'(1);
      first_q <= last_in ? 1'b0 : (s_axis_tuser || first_q);
    end
  end

  // second stage item
  logic [AW-1:0]    c1_q;
  logic             last1_q, use1_q, fs1_q;
  logic [PIX_W-1:0] pix1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_xfer) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      c1_q    <= c_in;
      last1_q <= last_in;
      use1_q  <= use_in;
      fs1_q   <= s_axis_tuser;
      pix1_q  <= s_axis_tdata;
    end
  end

  // line store and write port
  logic                  we;
  logic [AW-1:0]         wa;
  logic [LINE_ERR_W-1:0] wd;
  logic [LINE_ERR_W-1:0] rdata;

  edd_line_mem #(
    .DEPTH  (MAX_LINE_WIDTH),
    .DATA_W (LINE_ERR_W)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa),
    .wdata_i (wd),
    .re_i    (s_xfer),
    .raddr_i (c_in),
    .rdata_o (rdata)
  );

  logic                  pend_v_q;
  logic [AW-1:0]         pend_a_q;
  logic [LINE_ERR_W-1:0] pend_d_q;
  logic                  fwd_v_q;
  logic [LINE_ERR_W-1:0] fwd_d_q;
  logic signed [LINE_ERR_W-1:0] line_val;

  always_comb begin
    if (pend_v_q && (pend_a_q == c1_q)) begin
      line_val = $signed(pend_d_q);
    end else if (fwd_v_q) begin
      line_val = $signed(fwd_d_q);
    end else begin
      line_val = $signed(rdata);
    end
  end

  // error arithmetic
  logic signed [11:0] rc_q, pbl_q, rc_eff, pbl_eff;
  logic signed [9:0]  pbh_q, pbh_eff;
  logic signed [13:0] sum;
  logic signed [9:0]  sum_div;
  logic signed [10:0] adj;
  logic               white;
  logic signed [9:0]  e;
  logic signed [11:0] e12, e7, pbl_new;
  logic signed [12:0] e13, below_left;

  assign rc_eff  = fs1_q ? '0 : rc_q;
  assign pbl_eff = fs1_q ? '0 : pbl_q;
  assign pbh_eff = fs1_q ? '0 : pbh_q;

  assign sum     = {{2{rc_eff[11]}}, rc_eff} + (use1_q ? {line_val[12], line_val} : 14'sd0);
  assign sum_div = sum[13:4];
  assign adj     = $signed({3'b000, pix1_q}) + {sum_div[9], sum_div};
  assign white   = adj >= $signed({3'b000, threshold_q});
  assign e       = white ? 10'(adj - 11'sd255) : adj[9:0];

  assign e12        = {{2{e[9]}}, e};
  assign e13        = {{3{e[9]}}, e};
  assign e7         = e12 * 12'sd7;
  assign pbl_new    = {{2{pbh_eff[9]}}, pbh_eff} + e12 * 12'sd5;
  assign below_left = {pbl_eff[11], pbl_eff} + e13 * 13'sd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q  <= '0;
      pbl_q <= '0;
      pbh_q <= '0;
    end else if (s1_adv) begin
      if (last1_q) begin
        rc_q  <= '0;
        pbl_q <= '0;
        pbh_q <= '0;
      end else begin
        rc_q  <= e7;
        pbl_q <= pbl_new;
        pbh_q <= e;
      end
    end
  end

  // write selection: stage write first, deferred row-end write otherwise
  logic                  s1_we;
  logic [AW-1:0]         s1_wa;
  logic [LINE_ERR_W-1:0] s1_wd;
  logic                  defer;

  always_comb begin
    s1_we = 1'b0;
    s1_wa = c1_q;
    s1_wd = {pbl_new[11], pbl_new};
    defer = 1'b0;
    if (s1_adv) begin
      if (c1_q != '0) begin
        s1_we = 1'b1;
        s1_wa = c1_q - AW'(1);
        s1_wd = below_left;
        defer = last1_q;
      end else if (last1_q) begin
        s1_we = 1'b1;
      end
    end
  end

  assign we = s1_we || pend_v_q;
  assign wa = s1_we ? s1_wa : pend_a_q;
  assign wd = s1_we ? s1_wd : pend_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (defer) begin
      pend_v_q <= 1'b1;
    end else if (!s1_we) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (defer) begin
      pend_a_q <= c1_q;
      pend_d_q <= {pbl_new[11], pbl_new};
    end
  end

  // forward writes that the registered read missed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (s_xfer) begin
      fwd_v_q <= we && (wa == c_in);
    end else if (s1_v_q && !s1_adv && we && (wa == c1_q)) begin
      fwd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer || (s1_v_q && !s1_adv && we && (wa == c1_q))) begin
      fwd_d_q <= wd;
    end
  end

  // output register
  logic [PIX_W-1:0] out_pix_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pix_q  <= white ? PIX_WHITE : PIX_BLACK;
      out_last_q <= last1_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> design/edd_checker.sv
module edd_checker
  import edd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [PIX_W-1:0] m_axis_tdata,
  input  logic             m_axis_tlast
);

  logic [1:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == PIX_WHITE) || (m_axis_tdata == PIX_BLACK))
    else $error("result pixel neither black nor white");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q <= 2'd2) && (!m_axis_tvalid || (inflight_q != 2'd0)))
    else $error("result count does not match accepted pixels");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/dither_checker.sv
module dither_checker
  import edd_pkg::*;
#(
  parameter int MAX_W = DEFAULT_MAX_LINE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [PIX_W-1:0]       in_pixel_i,
  input  logic                   in_frame_start_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [PIX_W-1:0]       out_pixel_i,
  input  logic                   out_row_end_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     backlog_o
);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
  } dither_out_t;

  logic signed [LINE_ERR_W-1:0] err_line [MAX_W];
  logic signed [LINE_ERR_W-1:0] carry_right    = '0;
  logic signed [LINE_ERR_W-1:0] acc_below_left = '0;
  logic signed [LINE_ERR_W-1:0] acc_below_here = '0;
  logic [9:0]                   col            = '0;
  logic                         top_row        = 1'b1;
  logic [LINE_WIDTH_W-1:0]      width_q        = DEFAULT_LINE_WIDTH;
  logic [THRESHOLD_W-1:0]       thresh_q       = DEFAULT_THRESHOLD;

  dither_out_t dithered_q [$];
  int          mismatches = 0;
  int          waiting    = 0;

  assign fail_count_o = mismatches;
  assign backlog_o    = waiting;

  function automatic dither_out_t dither_next(input logic [PIX_W-1:0] pix, input logic fs);
    int          w;
    int          c;
    int          sum;
    int          adj;
    int          err;
    dither_out_t r;
    w = width_q;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (fs) begin
      col            = '0;
      carry_right    = '0;
      acc_below_left = '0;
      acc_below_here = '0;
      top_row        = 1'b1;
    end
    c = col;
    if (c >= MAX_W) c = MAX_W - 1;
    r.row_end = (c + 1 >= w);
    sum = carry_right;
    if (!top_row) sum += err_line[c];
    adj   = int'(pix) + (sum >>> 4);
    r.pix = (adj >= int'(thresh_q)) ? PIX_WHITE : PIX_BLACK;
    err   = adj - int'(r.pix);
    carry_right = LINE_ERR_W'(7 * err);
    if (c > 0) err_line[c-1] = LINE_ERR_W'(acc_below_left + 3 * err);
    acc_below_left = LINE_ERR_W'(acc_below_here + 5 * err);
    acc_below_here = LINE_ERR_W'(err);
    if (r.row_end) begin
      err_line[c]    = acc_below_left;
      carry_right    = '0;
      acc_below_left = '0;
      acc_below_here = '0;
      col            = '0;
      top_row        = 1'b0;
    end else begin
      col = 10'(c + 1);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dither_out_t exp_item;
    if (!rst_ni) begin
      for (int k = 0; k < MAX_W; k++) err_line[k] = '0;
      carry_right    = '0;
      acc_below_left = '0;
      acc_below_here = '0;
      col            = '0;
      top_row        = 1'b1;
      width_q        = DEFAULT_LINE_WIDTH;
      thresh_q       = DEFAULT_THRESHOLD;
      dithered_q.delete();
      waiting        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_LINE_WIDTH) begin
          width_q = cfg_data_i[LINE_WIDTH_W-1:0];
        end else if (cfg_index_i == REG_THRESHOLD) begin
          thresh_q = cfg_data_i[THRESHOLD_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        dithered_q.push_back(dither_next(in_pixel_i, in_frame_start_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (dithered_q.size() == 0) begin
          $error("unexpected transfer: out_pixel %0d, row_end %0d", out_pixel_i, out_row_end_i);
          mismatches++;
        end else begin
          exp_item = dithered_q.pop_front();
          if (out_pixel_i !== exp_item.pix) begin
            $error("out_pixel: expected %0d, actual %0d", exp_item.pix, out_pixel_i);
            mismatches++;
          end
          if (out_row_end_i !== exp_item.row_end) begin
            $error("row_end: expected %0d, actual %0d", exp_item.row_end, out_row_end_i);
            mismatches++;
          end
        end
      end
      waiting = dithered_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import edd_pkg::*;

  localparam int MAX_W       = DEFAULT_MAX_LINE_WIDTH;
  localparam int CYCLE_LIMIT = 200_000;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [PIX_W-1:0]       s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [PIX_W-1:0]       m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = REG_LINE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  int fail_count;
  int backlog;
  int cycles       = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // position in the frame, kept so that no row reads line entries never written
  int pos_col     = 0;
  bit pos_top_row = 1'b1;
  int line_filled = 0;
  int eff_width   = DEFAULT_LINE_WIDTH;

  error_diffusion_dither i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  dither_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_pixel_i       (s_axis_tdata),
    .in_frame_start_i (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_pixel_i      (m_axis_tdata),
    .out_row_end_i    (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .backlog_o        (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_LINE_WIDTH) begin
      eff_width = (data == 0) ? 1 : ((data > MAX_W) ? MAX_W : int'(data));
    end
  endtask

  // hold the input idle until every result has been transferred
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (backlog != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int c;
    if (!fs && !pos_top_row && pos_col >= line_filled) fs = 1'b1;
    if (fs) begin
      pos_col     = 0;
      pos_top_row = 1'b1;
    end
    c = pos_col;
    if (c > line_filled) line_filled = c;
    if (c + 1 >= eff_width) begin
      if (c + 1 > line_filled) line_filled = c + 1;
      pos_col     = 0;
      pos_top_row = 1'b0;
    end else begin
      pos_col = c + 1;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int lvl);
    logic [PIX_W-1:0] p;
    case ($urandom_range(3))
      0:       p = PIX_W'($urandom_range(255));
      1:       p = $urandom_range(1) ? PIX_WHITE : PIX_BLACK;
      default: p = PIX_W'(lvl + int'($urandom_range(6)) - 3);
    endcase
    return p;
  endfunction

  task automatic run_frames(input int n_items, input int lvl, input bit resize);
    int   pause_at;
    logic fs;
    pause_at = $urandom_range(n_items - 1);
    for (int k = 0; k < n_items; k++) begin
      if (k == pause_at) begin
        drain();
        if (resize && $urandom_range(1)) write_reg(REG_LINE_WIDTH, $urandom_range(1, 24));
      end
      fs = (k == 0) || (pos_col == 0 && $urandom_range(149) == 0) ||
           ($urandom_range(399) == 0);
      send_pixel(pick_pixel(lvl), fs);
    end
  endtask

  initial begin
    int width_sel;
    int thr_sel;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults, no frame start
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd127, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd254, 1'b0);

    drain();
    write_reg(REG_LINE_WIDTH, 3);
    write_reg(REG_THRESHOLD, 0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b0);

    drain();
    write_reg(REG_LINE_WIDTH, 0);
    write_reg(REG_THRESHOLD, 255);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);

    drain();
    write_reg(REG_SPARE_A, 2047);
    write_reg(REG_SPARE_B, 2047);
    write_reg(REG_LINE_WIDTH, 6);
    write_reg(REG_THRESHOLD, 128);
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd60, 1'b0);
    send_pixel(8'd130, 1'b0);
    send_pixel(8'd10, 1'b0);

    // shrink the row below the current column
    drain();
    write_reg(REG_LINE_WIDTH, 2);
    send_pixel(8'd100, 1'b0);
    send_pixel(8'd90, 1'b0);
    send_pixel(8'd80, 1'b0);

    for (int p = 0; p < 10; p++) begin
      drain();
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      case (p)
        2:       width_sel = 2047;
        5:       width_sel = 0;
        7:       width_sel = 1;
        default: width_sel = $urandom_range(2, 40);
      endcase
      case (p)
        1:       thr_sel = 0;
        4:       thr_sel = 255;
        8:       thr_sel = 1;
        default: thr_sel = $urandom_range(255);
      endcase
      write_reg(REG_LINE_WIDTH, width_sel);
      write_reg(REG_THRESHOLD, thr_sel);
      run_frames(68, $urandom_range(255), 1'b1);
    end

    // a run of MAX_W + 20 pixels at the widest setting
    drain();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_reg(REG_LINE_WIDTH, MAX_W);
    write_reg(REG_THRESHOLD, 128);
    run_frames(MAX_W + 20, $urandom_range(255), 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
